>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the checker modules.
// Both macros sample on the rising edge of clk and are held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/lsre_pkg.sv
package lsre_pkg;

  // Major opcodes of the memory instructions that are handled.
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_FLOAD  = 7'h07;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_FSTORE = 7'h27;

  // funct3 codes that are singled out during decode.
  localparam logic [2:0] F3_WORD       = 3'd2;
  localparam logic [2:0] F3_DOUBLE     = 3'd3;
  localparam logic [2:0] F3_LOAD_UNDEF = 3'd7;

  // Integer registers that get special treatment.
  localparam logic [4:0] XREG_ZERO = 5'd0;
  localparam logic [4:0] XREG_SP   = 5'd2;
  localparam logic [4:0] XREG_GP   = 5'd3;

  // Access sizes.
  localparam logic [1:0] SIZE_BYTE   = 2'd0;
  localparam logic [1:0] SIZE_HALF   = 2'd1;
  localparam logic [1:0] SIZE_WORD   = 2'd2;
  localparam logic [1:0] SIZE_DOUBLE = 2'd3;

  localparam logic [31:0] NAN_BOX_HI = 32'hFFFF_FFFF;

  // Configuration port geometry: three 64-bit registers at a stride of eight bytes.
  localparam int CFG_DW = 64;
  localparam int CFG_AW = 5;
  localparam logic [1:0] REG_TRAMPOLINE = 2'd0;
  localparam logic [1:0] REG_BACKUP     = 2'd1;
  localparam logic [1:0] REG_GP         = 2'd2;
  localparam logic [1:0] REG_UNUSED     = 2'd3;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_OPCODE    = 3'd1,
    ERR_FUNCT3    = 3'd2,
    ERR_WRITES_SP = 3'd3,
    ERR_WRITES_GP = 3'd4
  } err_t;

  // Request as it arrives on the input stream, lowest field last.
  typedef struct packed {
    logic [63:0] memory_data;
    logic [63:0] source_value;
    logic [63:0] base_value;
    logic [31:0] instruction_word;
  } in_item_t;

  // Result as it leaves on the output stream, lowest field last.
  typedef struct packed {
    logic [2:0]  pad;
    logic [63:0] writeback_value;
    logic        writeback_enable;
    logic        dest_is_float;
    logic [4:0]  dest_index;
    logic [63:0] store_data;
    logic [1:0]  access_size_log2;
    logic        access_is_write;
    logic [63:0] access_address;
    err_t        error_code;
  } out_item_t;

  localparam int IN_W  = $bits(in_item_t);
  localparam int OUT_W = $bits(out_item_t);

  // Keeps the low 2^lg bytes of a value.
  function automatic logic [63:0] width_mask(input logic [63:0] v, input logic [1:0] lg);
    logic [63:0] r;
    case (lg)
      SIZE_BYTE: r = {56'd0, v[7:0]};
      SIZE_HALF: r = {48'd0, v[15:0]};
      SIZE_WORD: r = {32'd0, v[31:0]};
      default:   r = v;
    endcase
    return r;
  endfunction

  // Sign or zero extension of the low 2^lg bytes.
  function automatic logic [63:0] load_extend(input logic [63:0] v, input logic [1:0] lg,
                                              input logic uns);
    logic [63:0] r;
    case (lg)
      SIZE_BYTE: r = {{56{v[7]  & ~uns}}, v[7:0]};
      SIZE_HALF: r = {{48{v[15] & ~uns}}, v[15:0]};
      SIZE_WORD: r = {{32{v[31] & ~uns}}, v[31:0]};
      default:   r = v;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/load_store_relocating_emulator_unit.sv
// Channel   Direction  Handshake                       Contents
// in_       slave      in_tvalid / in_tready           one faulting memory instruction request
// out_      master     out_tvalid / out_tready         decoded, relocated access and write-back
// cfg_      APB slave  psel, penable, pwrite, pready   page bases and global pointer
//
// One request is taken per cycle while the output is not stalled.
// The three register stages are decode, relocation add with load extension, and the
// final add into the backup page that feeds the output register.
// Reset clears the valid bits and sets all configuration registers to zero.
// A stall at the output holds each stage that has no free slot behind it, and empty
// stages keep filling, so nothing is lost or repeated.
module load_store_relocating_emulator_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // instruction_word, base_value, source_value, memory_data
  input  logic [lsre_pkg::IN_W-1:0]      in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // error_code, access_address, access_is_write, access_size_log2, store_data,
  // dest_index, dest_is_float, writeback_enable, writeback_value, zero padding
  output logic [lsre_pkg::OUT_W-1:0]     out_tdata,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [lsre_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [lsre_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [lsre_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                           cfg_pready
);
  import lsre_pkg::*;

  typedef struct packed {
    err_t        err;
    logic        is_store;
    logic        is_float;
    logic        uns;
    logic [1:0]  lg;
    logic [4:0]  rd;
    logic        wen;
    logic [11:0] imm;
    logic [63:0] base;
    logic [63:0] sdata;
    logic [63:0] mdata;
  } s1_t;

  typedef struct packed {
    err_t        err;
    logic        is_store;
    logic        is_float;
    logic [1:0]  lg;
    logic [4:0]  rd;
    logic        wen;
    logic [63:0] part_addr;
    logic [63:0] sdata;
    logic [63:0] wval;
  } s2_t;

  logic [63:0] tramp_r, backup_r, gp_r;
  logic        v1_r, v2_r, v3_r;
  logic        rdy1, rdy2, rdy3;
  s1_t         s1_r, s1_nxt;
  s2_t         s2_r, s2_nxt;
  out_item_t   out_r, out_nxt;
  in_item_t    req;
  logic [1:0]  cfg_idx;

  // Configuration registers and read-back.
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_AW-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tramp_r  <= '0;
      backup_r <= '0;
      gp_r     <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (cfg_idx)
        REG_TRAMPOLINE: tramp_r  <= cfg_pwdata;
        REG_BACKUP:     backup_r <= cfg_pwdata;
        REG_GP:         gp_r     <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TRAMPOLINE: cfg_prdata = tramp_r;
      REG_BACKUP:     cfg_prdata = backup_r;
      REG_GP:         cfg_prdata = gp_r;
      default:        cfg_prdata = '0;
    endcase
  end

  // Stage handshakes: a stage advances when it is empty or the one behind it moves.
  assign rdy3       = !v3_r || out_tready;
  assign rdy2       = !v2_r || rdy3;
  assign rdy1       = !v1_r || rdy2;
  assign in_tready  = rdy1;
  assign out_tvalid = v3_r;
  assign out_tdata  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1_r  <= s1_nxt;
    if (rdy2) s2_r  <= s2_nxt;
    if (rdy3) out_r <= out_nxt;
  end

  // Stage one: decode, error checks, operand selection and store data.
  assign req = in_tdata;

  always_comb begin
    logic [31:0] w;
    logic [6:0]  opc;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic        is_ld, is_st, fl, ok;
    logic [63:0] sval;
    err_t        err;

    w     = req.instruction_word;
    opc   = w[6:0];
    rd    = w[11:7];
    f3    = w[14:12];
    rs1   = w[19:15];
    rs2   = w[24:20];
    is_ld = (opc == OPC_LOAD)  || (opc == OPC_FLOAD);
    is_st = (opc == OPC_STORE) || (opc == OPC_FSTORE);
    fl    = (opc == OPC_FLOAD) || (opc == OPC_FSTORE);
    err   = ERR_NONE;

    // An unknown opcode wins over a bad funct3, which wins over the destination checks.
    if (!is_ld && !is_st) begin
      err = ERR_OPCODE;
    end else if (fl && f3 != F3_WORD && f3 != F3_DOUBLE) begin
      err = ERR_FUNCT3;
    end else if (is_ld && !fl && f3 == F3_LOAD_UNDEF) begin
      err = ERR_FUNCT3;
    end else if (is_st && !fl && f3[2]) begin
      err = ERR_FUNCT3;
    end else if (is_ld && !fl && rd == XREG_SP) begin
      err = ERR_WRITES_SP;
    end else if (is_ld && !fl && rd == XREG_GP) begin
      err = ERR_WRITES_GP;
    end
    ok = (err == ERR_NONE);

    // Integer stores read x0 as zero and x3 as the global pointer.
    if (fl) begin
      sval = req.source_value;
    end else if (rs2 == XREG_ZERO) begin
      sval = '0;
    end else if (rs2 == XREG_GP) begin
      sval = gp_r;
    end else begin
      sval = req.source_value;
    end

    s1_nxt.err      = err;
    s1_nxt.is_store = ok && is_st;
    s1_nxt.is_float = ok && is_ld && fl;
    s1_nxt.uns      = f3[2];
    s1_nxt.lg       = ok ? f3[1:0] : SIZE_BYTE;
    s1_nxt.rd       = (ok && is_ld) ? rd : XREG_ZERO;
    s1_nxt.wen      = ok && is_ld && (fl || rd != XREG_ZERO);
    s1_nxt.imm      = is_st ? {w[31:25], w[11:7]} : w[31:20];
    s1_nxt.sdata    = (ok && is_st) ? width_mask(sval, f3[1:0]) : '0;
    s1_nxt.mdata    = req.memory_data;
    if (rs1 == XREG_ZERO) begin
      s1_nxt.base = '0;
    end else if (rs1 == XREG_GP) begin
      s1_nxt.base = gp_r;
    end else begin
      s1_nxt.base = req.base_value;
    end
  end

  // Stage two: offset into the trampoline page and load value extension.
  always_comb begin
    s2_nxt.err       = s1_r.err;
    s2_nxt.is_store  = s1_r.is_store;
    s2_nxt.is_float  = s1_r.is_float;
    s2_nxt.lg        = s1_r.lg;
    s2_nxt.rd        = s1_r.rd;
    s2_nxt.wen       = s1_r.wen;
    s2_nxt.sdata     = s1_r.sdata;
    s2_nxt.part_addr = s1_r.base + {{52{s1_r.imm[11]}}, s1_r.imm} - tramp_r;
    if (!s1_r.wen) begin
      s2_nxt.wval = '0;
    end else if (s1_r.is_float && s1_r.lg == SIZE_WORD) begin
      s2_nxt.wval = {NAN_BOX_HI, s1_r.mdata[31:0]};
    end else if (s1_r.is_float) begin
      s2_nxt.wval = s1_r.mdata;
    end else begin
      s2_nxt.wval = load_extend(s1_r.mdata, s1_r.lg, s1_r.uns);
    end
  end

  // Stage three: move the address into the backup page and form the result.
  always_comb begin
    out_nxt.pad              = '0;
    out_nxt.error_code       = s2_r.err;
    out_nxt.access_address   = (s2_r.err == ERR_NONE) ? (s2_r.part_addr + backup_r) : '0;
    out_nxt.access_is_write  = s2_r.is_store;
    out_nxt.access_size_log2 = s2_r.lg;
    out_nxt.store_data       = s2_r.sdata;
    out_nxt.dest_index       = s2_r.rd;
    out_nxt.dest_is_float    = s2_r.is_float;
    out_nxt.writeback_enable = s2_r.wen;
    out_nxt.writeback_value  = s2_r.wval;
  end

endmodule

>>> hw/rtl/lsre_checker.sv
`include "assert_macros.svh"

module lsre_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [lsre_pkg::OUT_W-1:0]  out_tdata,
  input logic                        cfg_psel,
  input logic                        cfg_penable,
  input logic                        cfg_pwrite,
  input logic [lsre_pkg::CFG_AW-1:0] cfg_paddr,
  input logic [lsre_pkg::CFG_DW-1:0] cfg_pwdata,
  input logic [lsre_pkg::CFG_DW-1:0] cfg_prdata,
  input logic                        cfg_pready
);
  import lsre_pkg::*;

  out_item_t res;
  logic      cfg_wr;

  assign res    = out_tdata;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // A stalled result stays put until it is taken.
  `ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // A failed request carries nothing but its error code.
  `ASSERT_IMPL(a_err_clean, out_tvalid && res.error_code != ERR_NONE, res.access_address == '0 && !res.access_is_write && !res.writeback_enable && res.store_data == '0 && res.writeback_value == '0)

  // A store never writes a register back.
  `ASSERT_IMPL(a_store_no_wb, out_tvalid && res.access_is_write, !res.writeback_enable && res.dest_index == '0 && res.writeback_value == '0)

  // A register write is read back unchanged on the next cycle at the same address.
  `ASSERT_NEXT(a_cfg_readback, cfg_wr && cfg_paddr[CFG_AW-1:3] != REG_UNUSED, cfg_paddr != $past(cfg_paddr) || cfg_prdata == $past(cfg_pwdata))

endmodule

bind load_store_relocating_emulator_unit lsre_checker u_lsre_checker (.*);

>>> sim/load_store_relocating_emulator_unit_tb.sv
module load_store_relocating_emulator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsre_pkg::*;

  localparam int PIPE_DEPTH       = 3;
  localparam int MAX_WAIT         = 14;
  localparam int IDLE_LIMIT       = 2000;
  localparam int PHASES           = 7;
  localparam int RANDOM_PER_PHASE = 275;
  localparam int HOLD_AT          = 400;
  localparam int HOLD_CYCLES      = 120;

  // Keeps its own copy of the page bases and global pointer, works out the access that
  // each accepted request should produce and checks results against them in order.
  class relocation_checker;
    logic [63:0] trampoline_base = '0;
    logic [63:0] backup_base     = '0;
    logic [63:0] gp_value        = '0;
    out_item_t   pending_accesses[$];
    int          mismatches      = 0;

    function void set_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        REG_TRAMPOLINE: trampoline_base = val;
        REG_BACKUP:     backup_base = val;
        REG_GP:         gp_value = val;
        default: ;
      endcase
    endfunction

    // Integer register read: x0 is hard-wired to zero and x3 is the global pointer.
    function logic [63:0] int_reg(logic [4:0] idx, logic [63:0] given);
      if (idx == XREG_ZERO) return '0;
      if (idx == XREG_GP) return gp_value;
      return given;
    endfunction

    // Keeps the low 2^lg bytes and optionally copies the top kept bit upwards.
    function logic [63:0] sized(logic [63:0] v, logic [1:0] lg, logic sign_ext);
      int unsigned nbits;
      logic [63:0] mask;
      logic [63:0] r;
      nbits = 8 << lg;
      mask = (lg == SIZE_DOUBLE) ? '1 : ((64'd1 << nbits) - 64'd1);
      r = v & mask;
      if (sign_ext && lg != SIZE_DOUBLE && r[nbits-1]) r = r | ~mask;
      return r;
    endfunction

    function out_item_t predict_access(in_item_t req);
      logic [31:0] w;
      logic [6:0] opc;
      logic [4:0] rd;
      logic [4:0] rs1;
      logic [4:0] rs2;
      logic [2:0] f3;
      logic [63:0] imm_i;
      logic [63:0] imm_s;
      logic [63:0] base;
      logic is_load;
      logic is_float;
      out_item_t o;
      w = req.instruction_word;
      opc = w[6:0];
      rd = w[11:7];
      f3 = w[14:12];
      rs1 = w[19:15];
      rs2 = w[24:20];
      imm_i = {{52{w[31]}}, w[31:20]};
      imm_s = {{52{w[31]}}, w[31:25], w[11:7]};
      base = int_reg(rs1, req.base_value);
      is_load = (opc == OPC_LOAD) || (opc == OPC_FLOAD);
      is_float = (opc == OPC_FLOAD) || (opc == OPC_FSTORE);
      o = '0;
      // Errors are ranked: opcode first, then funct3, then the destination register.
      if (!is_load && opc != OPC_STORE && opc != OPC_FSTORE) begin
        o.error_code = ERR_OPCODE;
      end else if (is_float ? (f3 != F3_WORD && f3 != F3_DOUBLE)
                            : (is_load ? (f3 == F3_LOAD_UNDEF) : f3[2])) begin
        o.error_code = ERR_FUNCT3;
      end else if (is_load && !is_float && rd == XREG_SP) begin
        o.error_code = ERR_WRITES_SP;
      end else if (is_load && !is_float && rd == XREG_GP) begin
        o.error_code = ERR_WRITES_GP;
      end else begin
        o.access_address = base + (is_load ? imm_i : imm_s) - trampoline_base + backup_base;
        o.access_size_log2 = f3[1:0];
        if (is_load) begin
          o.dest_index = rd;
          o.dest_is_float = is_float;
          if (is_float) begin
            // Single-precision values are NaN-boxed in the upper word.
            o.writeback_enable = 1'b1;
            o.writeback_value = (f3 == F3_WORD) ? {NAN_BOX_HI, req.memory_data[31:0]}
                                                : req.memory_data;
          end else if (rd != XREG_ZERO) begin
            o.writeback_enable = 1'b1;
            o.writeback_value = sized(req.memory_data, f3[1:0], !f3[2]);
          end
        end else begin
          o.access_is_write = 1'b1;
          o.store_data = sized(is_float ? req.source_value : int_reg(rs2, req.source_value),
                               f3[1:0], 1'b0);
        end
      end
      return o;
    endfunction

    function void note_request(in_item_t req);
      pending_accesses.push_back(predict_access(req));
    endfunction

    function int outstanding();
      return pending_accesses.size();
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %h, got %h", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_accesses.size() == 0) begin
        $error("result %h arrived with no request outstanding", got);
        mismatches++;
        return;
      end
      want = pending_accesses.pop_front();
      compare_field("error_code", want.error_code, got.error_code);
      compare_field("access_address", want.access_address, got.access_address);
      compare_field("access_is_write", want.access_is_write, got.access_is_write);
      compare_field("access_size_log2", want.access_size_log2, got.access_size_log2);
      compare_field("store_data", want.store_data, got.store_data);
      compare_field("dest_index", want.dest_index, got.dest_index);
      compare_field("dest_is_float", want.dest_is_float, got.dest_is_float);
      compare_field("writeback_enable", want.writeback_enable, got.writeback_enable);
      compare_field("writeback_value", want.writeback_value, got.writeback_value);
    endfunction
  endclass

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_tvalid   = 1'b0;
  logic               in_tready;
  in_item_t           in_tdata    = '0;
  logic               out_tvalid;
  logic               out_tready  = 1'b0;
  logic [OUT_W-1:0]   out_tdata;
  logic               cfg_psel    = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]  cfg_paddr   = '0;
  logic [CFG_DW-1:0]  cfg_pwdata  = '0;
  logic [CFG_DW-1:0]  cfg_prdata;
  logic               cfg_pready;

  relocation_checker  sb;
  logic               idle_on      = 1'b1;
  int                 results_seen = 0;
  int                 quiet_cycles = 0;

  load_store_relocating_emulator_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Builds a memory instruction word; a load's low immediate is rs2, a store's is rd.
  function automatic logic [31:0] encode_access(logic [6:0] opc, logic [2:0] f3, logic [4:0] rd,
                                                logic [4:0] rs1, logic [4:0] rs2,
                                                logic [6:0] hi);
    return {hi, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic in_item_t build_request(logic [31:0] insn, logic [63:0] base,
                                             logic [63:0] src, logic [63:0] mem);
    in_item_t r;
    r.instruction_word = insn;
    r.base_value = base;
    r.source_value = src;
    r.memory_data = mem;
    return r;
  endfunction

  function automatic logic [63:0] random_word();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = '1;
      2:       v = 64'd1 << $urandom_range(0, 63);
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // Register numbers lean towards the ones with special meaning.
  function automatic logic [4:0] pick_reg();
    logic [4:0] r;
    case ($urandom_range(0, 11))
      0:       r = XREG_ZERO;
      1:       r = XREG_SP;
      2:       r = XREG_GP;
      default: r = 5'($urandom);
    endcase
    return r;
  endfunction

  // Mostly well-formed accesses with random content, plus bad funct3, bad opcodes and noise.
  function automatic in_item_t random_request();
    int pick;
    logic [6:0] opc;
    logic [2:0] f3;
    logic [31:0] insn;
    logic [63:0] base;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0:       opc = OPC_LOAD;
      1:       opc = OPC_FLOAD;
      2:       opc = OPC_STORE;
      default: opc = OPC_FSTORE;
    endcase
    if (opc == OPC_FLOAD || opc == OPC_FSTORE) f3 = $urandom_range(0, 1) ? F3_WORD : F3_DOUBLE;
    else if (opc == OPC_LOAD) f3 = 3'($urandom_range(0, 6));
    else f3 = 3'($urandom_range(0, 3));
    if (pick < 8) f3 = 3'($urandom_range(0, 7));
    if (pick >= 92 && pick < 96) opc = 7'($urandom_range(0, 127));
    insn = encode_access(opc, f3, pick_reg(), pick_reg(), pick_reg(), 7'($urandom));
    if (pick >= 96) insn = $urandom;
    base = $urandom_range(0, 1) ? sb.trampoline_base + $urandom_range(0, 4095) : random_word();
    return build_request(insn, base, random_word(), random_word());
  endfunction

  // Offers one request after a random gap and returns at the falling edge after it is taken.
  task automatic send_request(input in_item_t r);
    int wait_cycles;
    wait_cycles = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (wait_cycles > 0) begin
      in_tvalid <= 1'b0;
      repeat (wait_cycles) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= r;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(r);
    @(negedge clk);
  endtask

  // Setup and access phases, then the bus goes idle before the next transfer.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // Lets the pipeline empty before any register changes.
  task automatic reconfigure(input logic [63:0] tramp, input logic [63:0] backup,
                             input logic [63:0] gp);
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
    write_reg(REG_TRAMPOLINE, tramp);
    write_reg(REG_BACKUP, backup);
    write_reg(REG_GP, gp);
  endtask

  task automatic send_directed();
    logic [63:0] near;
    logic [63:0] neg_mem;
    logic [63:0] pos_mem;
    logic [63:0] src;
    near = sb.trampoline_base + 64'h123;
    neg_mem = 64'h8000_0000_8000_8080;
    pos_mem = 64'h7FFF_FFFF_7FFF_7F7F;
    src = 64'hFEDC_BA98_7654_3210;
    // Integer loads of every width, with the largest and smallest immediates.
    send_request(build_request(encode_access(OPC_LOAD, 3'd0, 5'd5, 5'd1, 5'd31, 7'h3F),
                               near, src, neg_mem));
    send_request(build_request(encode_access(OPC_LOAD, 3'd1, 5'd6, XREG_ZERO, 5'd0, 7'h40),
                               near, src, neg_mem));
    send_request(build_request(encode_access(OPC_LOAD, 3'd2, 5'd7, XREG_GP, 5'd4, 7'h00),
                               near, src, neg_mem));
    send_request(build_request(encode_access(OPC_LOAD, 3'd3, 5'd31, 5'd9, 5'd8, 7'h01),
                               '1, src, neg_mem));
    send_request(build_request(encode_access(OPC_LOAD, 3'd4, 5'd8, 5'd10, 5'd1, 7'h7F),
                               near, src, neg_mem));
    send_request(build_request(encode_access(OPC_LOAD, 3'd5, 5'd9, 5'd11, 5'd2, 7'h00),
                               near, src, neg_mem));
    send_request(build_request(encode_access(OPC_LOAD, 3'd6, 5'd10, 5'd12, 5'd3, 7'h00),
                               near, src, neg_mem));
    // Undefined funct3 outranks a write to the stack pointer.
    send_request(build_request(encode_access(OPC_LOAD, F3_LOAD_UNDEF, XREG_SP, 5'd1, 5'd0,
                                             7'h00), near, src, pos_mem));
    // Loads to x0, sp and gp.
    send_request(build_request(encode_access(OPC_LOAD, 3'd3, XREG_ZERO, 5'd1, 5'd0, 7'h00),
                               near, src, pos_mem));
    send_request(build_request(encode_access(OPC_LOAD, 3'd2, XREG_SP, 5'd1, 5'd0, 7'h00),
                               near, src, pos_mem));
    send_request(build_request(encode_access(OPC_LOAD, 3'd0, XREG_GP, 5'd1, 5'd0, 7'h00),
                               near, src, pos_mem));
    // Float loads may target any register; a half-word float load is rejected.
    send_request(build_request(encode_access(OPC_FLOAD, F3_WORD, XREG_ZERO, 5'd1, 5'd0, 7'h00),
                               near, src, pos_mem));
    send_request(build_request(encode_access(OPC_FLOAD, F3_DOUBLE, XREG_SP, 5'd1, 5'd0, 7'h00),
                               near, src, neg_mem));
    send_request(build_request(encode_access(OPC_FLOAD, F3_WORD, XREG_GP, 5'd1, 5'd0, 7'h00),
                               near, src, neg_mem));
    send_request(build_request(encode_access(OPC_FLOAD, 3'd1, 5'd4, 5'd1, 5'd0, 7'h00),
                               near, src, neg_mem));
    // Integer stores, including x0 and gp as the data source, and a bad funct3.
    send_request(build_request(encode_access(OPC_STORE, 3'd0, 5'd31, 5'd1, 5'd5, 7'h7F),
                               near, src, neg_mem));
    send_request(build_request(encode_access(OPC_STORE, 3'd1, 5'd0, 5'd1, XREG_ZERO, 7'h00),
                               near, src, neg_mem));
    send_request(build_request(encode_access(OPC_STORE, 3'd2, 5'd4, 5'd1, XREG_GP, 7'h00),
                               near, src, neg_mem));
    send_request(build_request(encode_access(OPC_STORE, 3'd3, 5'd31, XREG_GP, 5'd31, 7'h3F),
                               near, '1, neg_mem));
    send_request(build_request(encode_access(OPC_STORE, 3'd4, 5'd1, 5'd1, 5'd6, 7'h00),
                               near, src, neg_mem));
    // Float stores take the source value as given, even for register numbers 0 and 3.
    send_request(build_request(encode_access(OPC_FSTORE, F3_WORD, 5'd0, 5'd1, XREG_GP, 7'h40),
                               near, src, neg_mem));
    send_request(build_request(encode_access(OPC_FSTORE, F3_DOUBLE, 5'd2, 5'd1, XREG_ZERO,
                                             7'h00), near, src, neg_mem));
    send_request(build_request(encode_access(OPC_FSTORE, 3'd0, 5'd2, 5'd1, 5'd7, 7'h00),
                               near, src, neg_mem));
    // Opcodes outside the memory group.
    send_request(build_request(encode_access(7'h13, 3'd0, 5'd5, 5'd1, 5'd0, 7'h00),
                               near, src, neg_mem));
    send_request(build_request('1, '1, '1, '1));
  endtask

  // Result side: random stalls, one long hold to back the pipeline up, then check.
  initial begin
    int wait_cycles;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (results_seen == HOLD_AT) wait_cycles = HOLD_CYCLES;
      else wait_cycles = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (wait_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_result(out_tdata);
      results_seen++;
      @(negedge clk);
    end
  end

  // Ends the run if no request, result or register write gets through for too long.
  initial begin
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int p = 0; p < PHASES; p++) begin
      // Phases 1 and 4 run without gaps on either side.
      idle_on = (p % 3 != 1);
      case (p)
        0: reconfigure(64'h0000_7FFF_F000_0000, 64'h0000_5555_0000_1000,
                       64'h0000_0000_1000_8800);
        1: reconfigure('0, '0, '0);
        2: reconfigure('1, '1, '1);
        3: reconfigure({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        4: reconfigure('1, '0, {$urandom, $urandom});
        5: reconfigure('0, '1, 64'h8000_0000_0000_0000);
        default: reconfigure({$urandom, $urandom}, {$urandom, $urandom}, random_word());
      endcase
      if (p == 0) send_directed();
      for (int i = 0; i < RANDOM_PER_PHASE; i++) send_request(random_request());
    end
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (PIPE_DEPTH * 4) @(negedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
